/* hdl/bitmap_run_allocator_macros.svh */
// Assertion macros for the bitmap run allocator.
// Taken in by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bra_pkg.sv */
// Package for the bitmap run allocator: sizes, codes, state type, run mask helper.
// No dependencies; imported by bra_channels, bra_fit_unit and the top level.
package bra_pkg;

  localparam int NUM_REGIONS  = 16;
  localparam int REGION_SLOTS = 64;
  localparam int POS_W        = 6;
  localparam int REGION_W     = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int SLOT_W       = REGION_W + POS_W;
  localparam int TOTAL_SLOTS  = NUM_REGIONS * REGION_SLOTS;

  localparam int LEN_W    = 7;
  localparam int HANDLE_W = 10;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;
  localparam int PCT_W    = 7;
  localparam int PROD_W   = TOTAL_W + PCT_W;

  localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(100);
  localparam logic [LEN_W-1:0] MAX_RUN    = LEN_W'(REGION_SLOTS);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NO_FIT    = 2'd1,
    STS_NOT_ALLOC = 2'd2
  } bra_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_DONE
  } bra_state_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
  } bra_fit_t;

  function automatic logic [REGION_SLOTS-1:0] run_mask(input logic [LEN_W-1:0] len,
                                                       input logic [POS_W-1:0] pos);
    logic [REGION_SLOTS-1:0] m;
    if (len >= MAX_RUN) begin
      m = '1;
    end else begin
      m = (REGION_SLOTS'(1) << len) - REGION_SLOTS'(1);
    end
    return m << pos;
  endfunction

endpackage

/* hdl/bra_channels.sv */
// Handshake channel interfaces for the bitmap run allocator (request and result).
// Depends on bra_pkg for field widths.
interface bra_in_if import bra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [LEN_W-1:0]    run_length;
  logic [HANDLE_W-1:0] slot_handle;

  modport source (output valid, mode, run_length, slot_handle, input ready);
  modport sink   (input valid, mode, run_length, slot_handle, output ready);
endinterface

interface bra_out_if import bra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] granted_handle;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  slots_in_use;
  logic [PCT_W-1:0]    usage_percent;

  modport source (output valid, granted_handle, status, slots_in_use, usage_percent,
                  input ready);
  modport sink   (input valid, granted_handle, status, slots_in_use, usage_percent,
                  output ready);
endinterface

/* hdl/bra_fit_unit.sv */
// First-fit search over one 64-slot use map: lowest start of a free run of len slots.
// Depends on bra_pkg. Shared by every region step of the allocate scan.
module bra_fit_unit import bra_pkg::*; (
  input  logic [REGION_SLOTS-1:0] use_map,
  input  logic [LEN_W-1:0]        len,
  output bra_fit_t                fit
);

  always_comb begin
    logic [REGION_SLOTS-1:0] lvl [0:LEN_W-1];
    logic [REGION_SLOTS-1:0] win;
    logic [LEN_W-1:0]        off;
    // lvl[k][p]: slots p .. p+2^k-1 all free
    lvl[0] = ~use_map;
    for (int k = 1; k < LEN_W; k++) begin
      lvl[k] = lvl[k-1] & (lvl[k-1] >> (1 << (k - 1)));
    end
    win = '1;
    off = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if (len[k]) begin
        win = win & (lvl[k] >> off);
        off = off + LEN_W'(1 << k);
      end
    end
    fit.found = |win;
    fit.pos   = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (win[i]) begin
        fit.pos = POS_W'(i);
      end
    end
  end

endmodule

/* hdl/bra_size_ram.sv */
// Single-port RAM with registered read, holds the run length stored at each run head.
// No package dependencies.
module bra_size_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bitmap_run_allocator.sv */
// Bitmap run allocator top level: sequencer, use maps, slot counter, result register.
// Depends on bra_pkg, bra_channels, bra_fit_unit, bra_size_ram and the macro header.
//
// Usage:
//   in_chan carries one request per transfer: mode 0 allocates run_length contiguous
//   slots (first fit, lowest region then lowest position), mode 1 frees the run whose
//   head is slot_handle. out_chan returns exactly one result per request: the granted
//   handle, a status code, the slot count in use and the floored usage percent.
//   Allocate: the shared fit unit searches one region per scan step (1..16 regions),
//   then an update step and a result step follow before out valid.
//   A bad length skips the search and goes straight to the result step.
//   Free: run length read from the size RAM, then a check/update step and a result step.
//   One request is in flight at a time; in_chan.ready is high only while idle, so
//   a new request is taken only once the last result has entered the output register.
//   Reset (rst_n low, synchronous) clears the use maps and the count, then a clearing
//   pass writes zero to all 1024 size RAM entries, one per cycle, before ready rises.
//   If out_chan stalls, the finished result waits in the output register; a request
//   may be taken meanwhile and holds at its result step until the register frees.
`include "bitmap_run_allocator_macros.svh"

module bitmap_run_allocator import bra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bra_in_if.sink    in_chan,
  bra_out_if.source out_chan
);

  bra_state_t              state_r, state_nxt;
  logic [REGION_SLOTS-1:0] use_map_r [0:NUM_REGIONS-1];
  logic [TOTAL_W-1:0]      total_r;
  logic [SLOT_W-1:0]       clr_cnt_r;
  logic [REGION_W-1:0]     region_r;
  logic [POS_W-1:0]        pos_r;
  logic [LEN_W-1:0]        len_r;
  logic [HANDLE_W-1:0]     handle_r;
  logic [HANDLE_W-1:0]     granted_r;
  bra_status_t             status_r;

  logic                    out_valid_r;
  logic [HANDLE_W-1:0]     out_granted_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [TOTAL_W-1:0]      out_total_r;
  logic [PCT_W-1:0]        out_pct_r;

  logic                    in_xfer;
  logic                    out_free;
  logic                    len_ok;
  logic                    handle_ok;
  bra_fit_t                fit;
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_addr;
  logic [LEN_W-1:0]        ram_wdata;
  logic [LEN_W-1:0]        ram_rdata;
  logic [POS_W-1:0]        free_pos;
  logic [LEN_W:0]          free_end;
  logic                    free_ok;
  logic [PROD_W-1:0]       pct_prod;

  bra_fit_unit u_fit (
    .use_map (use_map_r[region_r]),
    .len     (len_r),
    .fit     (fit)
  );

  bra_size_ram #(
    .DEPTH (TOTAL_SLOTS),
    .WIDTH (LEN_W)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign len_ok    = (in_chan.run_length != '0) && (in_chan.run_length <= MAX_RUN);
  assign handle_ok = {1'b0, in_chan.slot_handle} < TOTAL_W'(TOTAL_SLOTS);
  assign free_pos  = handle_r[POS_W-1:0];
  assign free_end  = {2'b00, free_pos} + {1'b0, ram_rdata};
  assign free_ok   = (ram_rdata != '0) && (free_end <= (LEN_W+1)'(REGION_SLOTS)) &&
                     (total_r >= TOTAL_W'(ram_rdata));
  assign pct_prod  = PROD_W'(total_r) * PROD_W'(PCT_SCALE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SLOT_W'(TOTAL_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.mode == MODE_ALLOC) begin
            state_nxt = len_ok ? ST_SCAN : ST_DONE;
          end else begin
            state_nxt = handle_ok ? ST_FREE_RD : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (fit.found) begin
          state_nxt = ST_ALLOC;
        end else if (region_r == REGION_W'(NUM_REGIONS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_ALLOC:    state_nxt = ST_DONE;
      ST_FREE_RD:  state_nxt = ST_FREE_CHK;
      ST_FREE_CHK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = handle_r[SLOT_W-1:0];
    ram_wdata     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
      end
      ST_IDLE:  in_chan.ready = 1'b1;
      ST_ALLOC: begin
        ram_we    = 1'b1;
        ram_addr  = {region_r, pos_r};
        ram_wdata = len_r;
      end
      ST_FREE_CHK: ram_we = free_ok;
      ST_SCAN, ST_FREE_RD, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      total_r   <= '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
        use_map_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_CLEAR: clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
        ST_IDLE: begin
          if (in_xfer) begin
            len_r     <= in_chan.run_length;
            handle_r  <= in_chan.slot_handle;
            region_r  <= '0;
            granted_r <= '0;
            status_r  <= (in_chan.mode == MODE_ALLOC) ? STS_NO_FIT : STS_NOT_ALLOC;
          end
        end
        ST_SCAN: begin
          pos_r <= fit.pos;
          if (!fit.found && region_r != REGION_W'(NUM_REGIONS - 1)) begin
            region_r <= region_r + REGION_W'(1);
          end
        end
        ST_ALLOC: begin
          use_map_r[region_r] <= use_map_r[region_r] | run_mask(len_r, pos_r);
          total_r             <= total_r + TOTAL_W'(len_r);
          granted_r           <= HANDLE_W'({region_r, pos_r});
          status_r            <= STS_OK;
        end
        ST_FREE_CHK: begin
          if (free_ok) begin
            use_map_r[handle_r[SLOT_W-1:POS_W]] <=
              use_map_r[handle_r[SLOT_W-1:POS_W]] & ~run_mask(ram_rdata, free_pos);
            total_r  <= total_r - TOTAL_W'(ram_rdata);
            status_r <= STS_OK;
          end
        end
        ST_FREE_RD, ST_DONE: ;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_granted_r <= granted_r;
      out_status_r  <= status_r;
      out_total_r   <= total_r;
      out_pct_r     <= PCT_W'(pct_prod / TOTAL_SLOTS);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.granted_handle = out_granted_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.slots_in_use   = out_total_r;
  assign out_chan.usage_percent  = out_pct_r;

  `BRA_ASSERT_IMPL(a_total_bound, clk, rst_n, 1'b1, total_r <= TOTAL_W'(TOTAL_SLOTS), "slot count above capacity")
  `BRA_ASSERT_IMPL(a_fit_free, clk, rst_n, state_r == ST_ALLOC, (use_map_r[region_r] & run_mask(len_r, pos_r)) == '0, "granted run overlaps used slots")
  `BRA_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, state_r != ST_IDLE, "sequencer idle right after a request transfer")
  `BRA_ASSERT_IMPL(a_nofit_zero, clk, rst_n, out_valid_r && out_status_r != STS_OK, out_granted_r == '0, "nonzero handle on a failed request")

endmodule
